/* rtl/ax25_frame_parser_top_macros.svh */
// Assertion macros used by the frame parser top level.
`ifndef AX25_FRAME_PARSER_TOP_MACROS_SVH
`define AX25_FRAME_PARSER_TOP_MACROS_SVH

// Checked property with reset masking, sampled on the block clock.
`define AX25_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked property that must also hold while reset is applied.
`define AX25_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/ax25fp_pkg.sv */
`timescale 1ns / 1ps

package ax25fp_pkg;

  // Default digipeater limit.
  localparam int unsigned MaxDigipeatersDefault = 8;

  // Parser phases.
  typedef enum logic [2:0] {
    PhAddr,
    PhCtrl,
    PhPid,
    PhInfo,
    PhDrop,
    PhSkip
  } phase_e;

  // Record kinds.
  localparam logic [1:0] KindAddress = 2'd0;
  localparam logic [1:0] KindHeader  = 2'd1;
  localparam logic [1:0] KindPayload = 2'd2;
  localparam logic [1:0] KindStatus  = 2'd3;

  // Address roles.
  localparam logic [1:0] RoleDest  = 2'd0;
  localparam logic [1:0] RoleSrc   = 2'd1;
  localparam logic [1:0] RoleDigi  = 2'd2;

  // Frame types.
  localparam logic [3:0] TypeI       = 4'd0;
  localparam logic [3:0] TypeRr      = 4'd1;
  localparam logic [3:0] TypeRnr     = 4'd2;
  localparam logic [3:0] TypeRej     = 4'd3;
  localparam logic [3:0] TypeSabm    = 4'd4;
  localparam logic [3:0] TypeSabme   = 4'd5;
  localparam logic [3:0] TypeDisc    = 4'd6;
  localparam logic [3:0] TypeDm      = 4'd7;
  localparam logic [3:0] TypeUa      = 4'd8;
  localparam logic [3:0] TypeFrmr    = 4'd9;
  localparam logic [3:0] TypeUi      = 4'd10;
  localparam logic [3:0] TypeUnknown = 4'd11;

  // Frame status codes.
  localparam logic [1:0] StatOk        = 2'd0;
  localparam logic [1:0] StatTruncated = 2'd1;
  localparam logic [1:0] StatEmptyCall = 2'd2;
  localparam logic [1:0] StatDestLast  = 2'd3;

  // Control octet patterns, poll/final bit masked out.
  localparam logic [7:0] CtrlPfMask = 8'h10;
  localparam logic [7:0] CtrlUi     = 8'h03;
  localparam logic [7:0] CtrlDm     = 8'h0F;
  localparam logic [7:0] CtrlSabm   = 8'h2F;
  localparam logic [7:0] CtrlSabme  = 8'h6F;
  localparam logic [7:0] CtrlDisc   = 8'h43;
  localparam logic [7:0] CtrlUa     = 8'h63;
  localparam logic [7:0] CtrlFrmr   = 8'h87;

  // Supervisory function codes, bits 3..2 of the control octet.
  localparam logic [1:0] SupRr  = 2'b00;
  localparam logic [1:0] SupRnr = 2'b01;
  localparam logic [1:0] SupRej = 2'b10;

  // Six space characters after the address shift.
  localparam logic [47:0] AllSpaces = 48'h2020_2020_2020;

  // One result record.
  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  role;
    logic [47:0] call;
    logic [3:0]  ssid;
    logic        ch;
    logic [3:0]  ftype;
    logic        cmd;
    logic        pf;
    logic [2:0]  ns;
    logic [2:0]  nr;
    logic [7:0]  octet;
    logic [1:0]  status;
  } record_t;

  // Records produced by one accepted octet.
  typedef struct packed {
    logic    rec_valid;
    record_t rec;
    logic    stat_valid;
    record_t stat;
  } parse_out_t;

endpackage

/* rtl/ax25fp_parser.sv */
`timescale 1ns / 1ps

module ax25fp_parser #(
  parameter int unsigned MaxDigipeaters = ax25fp_pkg::MaxDigipeatersDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   end_of_frame_i,
  output ax25fp_pkg::parse_out_t out_o
);
  import ax25fp_pkg::*;

  // Address index at which the digipeater list is forced to end.
  localparam logic [3:0] LastIdx = 4'(MaxDigipeaters + 1);

  // Decoded control octet.
  typedef struct packed {
    logic [3:0] ftype;
    logic       pf;
    logic [2:0] ns;
    logic [2:0] nr;
    logic       pid;
    logic       info;
  } ctrl_t;

  function automatic ctrl_t decode_ctrl(logic [7:0] b);
    ctrl_t c;
    c       = '0;
    c.pf    = b[4];
    c.ftype = TypeUnknown;
    if (!b[0]) begin
      c.ftype = TypeI;
      c.ns    = b[3:1];
      c.nr    = b[7:5];
      c.pid   = 1'b1;
    end else if (!b[1]) begin
      c.nr = b[7:5];
      case (b[3:2])
        SupRr:   c.ftype = TypeRr;
        SupRnr:  c.ftype = TypeRnr;
        SupRej:  c.ftype = TypeRej;
        default: c.ftype = TypeUnknown;
      endcase
    end else begin
      unique case (b & ~CtrlPfMask)
        CtrlUi: begin
          c.ftype = TypeUi;
          c.pid   = 1'b1;
        end
        CtrlDm:    c.ftype = TypeDm;
        CtrlSabm:  c.ftype = TypeSabm;
        CtrlSabme: c.ftype = TypeSabme;
        CtrlDisc:  c.ftype = TypeDisc;
        CtrlUa:    c.ftype = TypeUa;
        CtrlFrmr: begin
          c.ftype = TypeFrmr;
          c.info  = 1'b1;
        end
        default:   c.ftype = TypeUnknown;
      endcase
    end
    return c;
  endfunction

  phase_e      phase_q, phase_d;
  logic [2:0]  oct_q, oct_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [47:0] shift_q, shift_d;
  logic        dest_c_q, dest_c_d;
  logic        src_c_q, src_c_d;
  logic [10:0] pend_q, pend_d;
  logic [1:0]  err_q, err_d;
  phase_e      phase_mid;
  logic [1:0]  err_mid;
  ctrl_t       ctrl;
  logic        call_empty;
  logic [1:0]  role;

  assign ctrl       = decode_ctrl(data_byte_i);
  assign call_empty = (shift_q == AllSpaces);
  assign role       = (cnt_q == 4'd0) ? RoleDest : ((cnt_q == 4'd1) ? RoleSrc : RoleDigi);

  // Next state of the frame parser.
  always_comb begin
    phase_d   = phase_q;
    oct_d     = oct_q;
    cnt_d     = cnt_q;
    shift_d   = shift_q;
    dest_c_d  = dest_c_q;
    src_c_d   = src_c_q;
    pend_d    = pend_q;
    err_d     = err_q;
    phase_mid = phase_q;
    err_mid   = err_q;
    if (accept_i) begin
      unique case (phase_q)
        PhAddr: begin
          if (oct_q < 3'd6) begin
            shift_d = {shift_q[39:0], 1'b0, data_byte_i[7:1]};
            oct_d   = oct_q + 3'd1;
          end else begin
            shift_d = '0;
            oct_d   = '0;
            if (call_empty) begin
              err_d   = StatEmptyCall;
              phase_d = PhSkip;
            end else begin
              if (cnt_q == 4'd0) begin
                dest_c_d = data_byte_i[7];
              end else if (cnt_q == 4'd1) begin
                src_c_d = data_byte_i[7];
              end
              if (cnt_q == 4'd0 && data_byte_i[0]) begin
                err_d   = StatDestLast;
                phase_d = PhSkip;
              end else if (cnt_q != 4'd0 && (data_byte_i[0] || cnt_q >= LastIdx)) begin
                phase_d = PhCtrl;
              end
              if (cnt_q != 4'hF) begin
                cnt_d = cnt_q + 4'd1;
              end
            end
          end
        end
        PhCtrl: begin
          pend_d = {ctrl.nr, ctrl.ns, ctrl.pf, ctrl.ftype};
          if (ctrl.pid) begin
            phase_d = PhPid;
          end else if (ctrl.info) begin
            phase_d = PhInfo;
          end else begin
            phase_d = PhDrop;
          end
        end
        PhPid:   phase_d = PhInfo;
        default: phase_d = phase_q;
      endcase
      // Phase and status reached by this octet, before the frame-end restart.
      phase_mid = phase_d;
      err_mid   = err_d;
      // Frame end restarts the parser for the next frame.
      if (end_of_frame_i) begin
        phase_d  = PhAddr;
        oct_d    = '0;
        cnt_d    = '0;
        shift_d  = '0;
        dest_c_d = 1'b0;
        src_c_d  = 1'b0;
        pend_d   = '0;
        err_d    = StatOk;
      end
    end
  end

  // Records caused by the current octet.
  always_comb begin
    out_o            = '0;
    out_o.rec.cmd    = dest_c_q | ~src_c_q;
    out_o.stat.kind  = KindStatus;
    out_o.stat_valid = accept_i & end_of_frame_i;
    unique case (phase_q)
      PhAddr: begin
        out_o.rec_valid = accept_i && (oct_q >= 3'd6) && !call_empty;
        out_o.rec.kind  = KindAddress;
        out_o.rec.role  = role;
        out_o.rec.call  = shift_q;
        out_o.rec.ssid  = data_byte_i[4:1];
        out_o.rec.ch    = data_byte_i[7];
        out_o.rec.cmd   = 1'b0;
      end
      PhCtrl: begin
        out_o.rec_valid = accept_i & ~ctrl.pid;
        out_o.rec.kind  = KindHeader;
        out_o.rec.ftype = ctrl.ftype;
        out_o.rec.pf    = ctrl.pf;
        out_o.rec.ns    = ctrl.ns;
        out_o.rec.nr    = ctrl.nr;
      end
      PhPid: begin
        out_o.rec_valid = accept_i;
        out_o.rec.kind  = KindHeader;
        out_o.rec.ftype = pend_q[3:0];
        out_o.rec.pf    = pend_q[4];
        out_o.rec.ns    = pend_q[7:5];
        out_o.rec.nr    = pend_q[10:8];
        out_o.rec.octet = data_byte_i;
      end
      PhInfo: begin
        out_o.rec_valid = accept_i;
        out_o.rec.kind  = KindPayload;
        out_o.rec.octet = data_byte_i;
        out_o.rec.cmd   = 1'b0;
      end
      default: begin
        out_o.rec_valid = 1'b0;
        out_o.rec.cmd   = 1'b0;
      end
    endcase
    if (!out_o.rec_valid) begin
      out_o.rec = '0;
    end
    // Status reflects the phase and error reached after this octet.
    out_o.stat.status = err_mid;
    if (err_mid == StatOk && (phase_mid == PhAddr || phase_mid == PhCtrl ||
                              phase_mid == PhPid)) begin
      out_o.stat.status = StatTruncated;
    end
    if (!out_o.stat_valid) begin
      out_o.stat = '0;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhAddr;
      oct_q    <= '0;
      cnt_q    <= '0;
      shift_q  <= '0;
      dest_c_q <= 1'b0;
      src_c_q  <= 1'b0;
      pend_q   <= '0;
      err_q    <= StatOk;
    end else begin
      phase_q  <= phase_d;
      oct_q    <= oct_d;
      cnt_q    <= cnt_d;
      shift_q  <= shift_d;
      dest_c_q <= dest_c_d;
      src_c_q  <= src_c_d;
      pend_q   <= pend_d;
      err_q    <= err_d;
    end
  end

endmodule

/* rtl/ax25_frame_parser_top.sv */
`timescale 1ns / 1ps
// AX.25 frame parser, modulo-8 control field.
// Input stream: one frame octet per transaction in s_axis_tdata, with the frame
// check sequence already stripped; s_axis_tlast marks the final octet.
// Output stream: one record per transaction. m_axis_tuser carries the record
// kind (address, header, payload octet, frame status) and m_axis_tdata the
// record fields. Address records come per seven-octet address field, a header
// record after the control octet (or after the PID for I and UI frames), one
// payload record per information octet, and a status record after the last.
// Each record is registered in the result queue before it is offered.
// Throughput: one octet per cycle while the queue has room. Each octet gives
// at most one record, except the final octet, which can give two; a four-entry
// result queue absorbs the extra record, so the input stalls only when the queue
// holds three or more records. When the receiver stalls, the queue fills and
// s_axis_tready drops; no record is lost. Reset clears the parser to the start
// of a frame and empties the queue.

module ax25_frame_parser_top #(
  parameter int unsigned MaxDigipeaters = ax25fp_pkg::MaxDigipeatersDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: data_byte[7:0]
  input  logic [7:0]  s_axis_tdata_i,
  input  logic        s_axis_tlast_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: address_role[1:0], call_sign[49:2], station_ssid[53:50],
  // c_or_h_bit[54], frame_type[58:55], is_command[59], poll_final[60],
  // send_seq[63:61], recv_seq[66:64], octet_value[74:67],
  // frame_status[76:75], zero fill[79:77]
  output logic [79:0] m_axis_tdata_o,
  // tuser: record_kind[1:0]
  output logic [1:0]  m_axis_tuser_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i
);
  import ax25fp_pkg::*;

  localparam int unsigned Depth = 4;

  parse_out_t  pout;
  logic        accept;
  logic        pop;
  logic [1:0]  push_n;
  logic [1:0]  wr_q, wr_d;
  logic [1:0]  rd_q, rd_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [1:0]  stat_slot;
  record_t     mem_q [Depth];
  record_t     head;

  assign s_axis_tready_o = (cnt_q < 3'(Depth - 1));
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;
  assign pop             = m_axis_tvalid_o & m_axis_tready_i;

  ax25fp_parser #(
    .MaxDigipeaters(MaxDigipeaters)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (s_axis_tdata_i),
    .end_of_frame_i(s_axis_tlast_i),
    .out_o         (pout)
  );

  // Queue bookkeeping.
  assign push_n    = 2'(pout.rec_valid) + 2'(pout.stat_valid);
  assign stat_slot = pout.rec_valid ? (wr_q + 2'd1) : wr_q;

  always_comb begin
    wr_d  = wr_q + push_n;
    rd_d  = pop ? (rd_q + 2'd1) : rd_q;
    cnt_d = cnt_q + 3'(push_n) - 3'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Record storage, up to two writes per cycle.
  always_ff @(posedge clk_i) begin
    if (pout.rec_valid) begin
      mem_q[wr_q] <= pout.rec;
    end
    if (pout.stat_valid) begin
      mem_q[stat_slot] <= pout.stat;
    end
  end

  // Output side.
  assign head            = mem_q[rd_q];
  assign m_axis_tvalid_o = (cnt_q != 3'd0);
  assign m_axis_tuser_o  = head.kind;
  assign m_axis_tdata_o  = {3'b000, head.status, head.octet, head.nr, head.ns, head.pf,
                            head.cmd, head.ftype, head.ch, head.ssid, head.call, head.role};

  `include "ax25_frame_parser_top_macros.svh"

  `AX25_ASSERT_RST(a_cnt_bound, cnt_q <= 3'(Depth), "result queue overfilled")
  `AX25_ASSERT_RST(a_ready_room, !s_axis_tready_o |-> cnt_q >= 3'(Depth - 1), "ready dropped with room")
  `AX25_ASSERT_RST(a_pop_only, (pop && push_n == 2'd0) |=> cnt_q == $past(cnt_q) - 3'd1, "queue count slip on pop")

endmodule

/* verif/ax25_frame_parser_top_tb.sv */
`timescale 1ns / 1ps

module ax25_frame_parser_top_tb;
  import ax25fp_pkg::*;

  localparam int unsigned MaxDigis = MaxDigipeatersDefault;
  localparam int DirectedLen = 24;
  localparam int StallLimit = 2000;
  localparam int HoldCycles = 300;
  localparam int DrainCycles = 16;

  // One row of the directed stimulus; stat is typed in only where typed is set.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    logic [1:0] stat;
  } stim_row_t;

  localparam stim_row_t DirectedRows [DirectedLen] = '{
    // A frame of one octet ends before any address is complete.
    '{8'hFF, 1'b1, 1'b1, StatTruncated},
    // Destination callsign of six spaces.
    '{8'h40, 1'b0, 1'b0, StatOk},
    '{8'h40, 1'b0, 1'b0, StatOk},
    '{8'h40, 1'b0, 1'b0, StatOk},
    '{8'h40, 1'b0, 1'b0, StatOk},
    '{8'h40, 1'b0, 1'b0, StatOk},
    '{8'h40, 1'b0, 1'b0, StatOk},
    '{8'hE1, 1'b1, 1'b1, StatEmptyCall},
    // Destination carries the end-of-address bit; the short frame keeps that status.
    '{8'h82, 1'b0, 1'b0, StatOk},
    '{8'h84, 1'b0, 1'b0, StatOk},
    '{8'h86, 1'b0, 1'b0, StatOk},
    '{8'h88, 1'b0, 1'b0, StatOk},
    '{8'h8A, 1'b0, 1'b0, StatOk},
    '{8'h8C, 1'b0, 1'b0, StatOk},
    '{8'h61, 1'b0, 1'b0, StatOk},
    '{8'h00, 1'b1, 1'b1, StatDestLast},
    // All-zero destination with SSID 15 and C set, frame ends inside the source.
    '{8'h00, 1'b0, 1'b0, StatOk},
    '{8'h00, 1'b0, 1'b0, StatOk},
    '{8'h00, 1'b0, 1'b0, StatOk},
    '{8'h00, 1'b0, 1'b0, StatOk},
    '{8'h00, 1'b0, 1'b0, StatOk},
    '{8'h00, 1'b0, 1'b0, StatOk},
    '{8'hFE, 1'b0, 1'b0, StatOk},
    '{8'h01, 1'b1, 1'b1, StatTruncated}
  };

  logic        clk_i;
  logic        rst_ni;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;

  // Records still owed by the block, oldest first.
  record_t expected_records[$];
  record_t seen_record;

  // Parser state mirrored by the predictor.
  phase_e      parser_phase;
  logic [2:0]  addr_octets;
  logic [3:0]  addr_fields;
  logic [47:0] call_shift;
  logic        dest_cbit;
  logic        src_cbit;
  record_t     pending_hdr;
  logic [1:0]  latched_status;

  int src_idle_pct;
  int sink_idle_pct;
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;
  int stall_cycles = 0;
  int mismatch_count = 0;
  int octets_sent = 0;
  int frames_sent = 0;
  int records_by_kind [4] = '{0, 0, 0, 0};
  logic [15:0] types_seen = '0;

  ax25_frame_parser_top #(
    .MaxDigipeaters(MaxDigis)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tlast_i (s_axis_tlast),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                 input logic [63:0] want_v);
    $display("mismatch at %0t ns: %s got 0x%0h expected 0x%0h", $time, what, got_v, want_v);
    mismatch_count++;
  endtask

  task automatic check_record(input record_t got, input record_t want);
    if (got.kind !== want.kind) report_mismatch("record_kind", got.kind, want.kind);
    if (got.role !== want.role) report_mismatch("address_role", got.role, want.role);
    if (got.call !== want.call) report_mismatch("call_sign", got.call, want.call);
    if (got.ssid !== want.ssid) report_mismatch("station_ssid", got.ssid, want.ssid);
    if (got.ch !== want.ch) report_mismatch("c_or_h_bit", got.ch, want.ch);
    if (got.ftype !== want.ftype) report_mismatch("frame_type", got.ftype, want.ftype);
    if (got.cmd !== want.cmd) report_mismatch("is_command", got.cmd, want.cmd);
    if (got.pf !== want.pf) report_mismatch("poll_final", got.pf, want.pf);
    if (got.ns !== want.ns) report_mismatch("send_seq", got.ns, want.ns);
    if (got.nr !== want.nr) report_mismatch("recv_seq", got.nr, want.nr);
    if (got.octet !== want.octet) report_mismatch("octet_value", got.octet, want.octet);
    if (got.status !== want.status) report_mismatch("frame_status", got.status, want.status);
  endtask

  function automatic record_t blank_record(input logic [1:0] kind);
    record_t r;
    r = '0;
    r.kind = kind;
    return r;
  endfunction

  function automatic record_t status_record(input logic [1:0] st);
    record_t r;
    r = blank_record(KindStatus);
    r.status = st;
    return r;
  endfunction

  task automatic clear_parser();
    parser_phase = PhAddr;
    addr_octets = '0;
    addr_fields = '0;
    call_shift = '0;
    dest_cbit = 1'b0;
    src_cbit = 1'b0;
    pending_hdr = '0;
    latched_status = StatOk;
  endtask

  // The header takes its command sense from both C bits and carries an optional PID.
  task automatic push_header(input logic [7:0] pid);
    record_t r;
    r = pending_hdr;
    r.cmd = dest_cbit | ~src_cbit;
    r.octet = pid;
    types_seen[r.ftype] = 1'b1;
    expected_records.push_back(r);
  endtask

  // Works out the records that one accepted octet causes and advances the state.
  task automatic predict_octet(input logic [7:0] b, input logic last);
    record_t r;
    logic pid_follows;
    logic info_follows;
    logic [1:0] st;
    case (parser_phase)
      PhAddr: begin
        if (addr_octets < 3'd6) begin
          call_shift = {call_shift[39:0], 1'b0, b[7:1]};
          addr_octets++;
        end else begin
          addr_octets = '0;
          if (call_shift == AllSpaces) begin
            latched_status = StatEmptyCall;
            parser_phase = PhSkip;
          end else begin
            r = blank_record(KindAddress);
            r.role = (addr_fields == 0) ? RoleDest : (addr_fields == 1) ? RoleSrc : RoleDigi;
            r.call = call_shift;
            r.ssid = b[4:1];
            r.ch = b[7];
            if (addr_fields == 0) dest_cbit = b[7];
            else if (addr_fields == 1) src_cbit = b[7];
            expected_records.push_back(r);
            if (addr_fields == 0 && b[0]) begin
              latched_status = StatDestLast;
              parser_phase = PhSkip;
            end else if (addr_fields >= 1 && (b[0] || addr_fields >= MaxDigis + 1)) begin
              parser_phase = PhCtrl;
            end
            if (addr_fields < 4'd15) addr_fields++;
          end
          call_shift = '0;
        end
      end
      PhCtrl: begin
        pending_hdr = blank_record(KindHeader);
        pending_hdr.pf = b[4];
        pending_hdr.ftype = TypeUnknown;
        pid_follows = 1'b0;
        info_follows = 1'b0;
        if (!b[0]) begin
          pending_hdr.ftype = TypeI;
          pending_hdr.ns = b[3:1];
          pending_hdr.nr = b[7:5];
          pid_follows = 1'b1;
        end else if (b[1:0] == 2'b01) begin
          pending_hdr.nr = b[7:5];
          case (b[3:2])
            SupRr:   pending_hdr.ftype = TypeRr;
            SupRnr:  pending_hdr.ftype = TypeRnr;
            SupRej:  pending_hdr.ftype = TypeRej;
            default: pending_hdr.ftype = TypeUnknown;
          endcase
        end else begin
          case (b & ~CtrlPfMask)
            CtrlUi: begin
              pending_hdr.ftype = TypeUi;
              pid_follows = 1'b1;
            end
            CtrlDm:    pending_hdr.ftype = TypeDm;
            CtrlSabm:  pending_hdr.ftype = TypeSabm;
            CtrlSabme: pending_hdr.ftype = TypeSabme;
            CtrlDisc:  pending_hdr.ftype = TypeDisc;
            CtrlUa:    pending_hdr.ftype = TypeUa;
            CtrlFrmr: begin
              pending_hdr.ftype = TypeFrmr;
              info_follows = 1'b1;
            end
            default:   pending_hdr.ftype = TypeUnknown;
          endcase
        end
        if (pid_follows) begin
          parser_phase = PhPid;
        end else begin
          push_header(8'h00);
          parser_phase = info_follows ? PhInfo : PhDrop;
        end
      end
      PhPid: begin
        push_header(b);
        parser_phase = PhInfo;
      end
      PhInfo: begin
        r = blank_record(KindPayload);
        r.octet = b;
        expected_records.push_back(r);
      end
      default: begin
      end
    endcase

    // A frame that stops before its header is complete counts as truncated, unless an error status was latched.
    if (last) begin
      st = latched_status;
      if (st == StatOk &&
          (parser_phase == PhAddr || parser_phase == PhCtrl || parser_phase == PhPid)) begin
        st = StatTruncated;
      end
      expected_records.push_back(status_record(st));
      clear_parser();
    end
  endtask

  // Offers one octet after a random idle gap and predicts once it is taken.
  task automatic send_octet(input logic [7:0] data, input logic last);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata <= data;
    s_axis_tlast <= last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_octet(data, last);
    octets_sent++;
    if (last) frames_sent++;
  endtask

  // Holds the input idle until every owed record has come out.
  task automatic wait_for_records_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_records.size() != 0) @(posedge clk_i);
  endtask

  // Mostly well-formed frames with random content; the rest is noise, cut-off
  // frames, all-space callsigns and destinations that claim to be last.
  task automatic send_random_frame();
    logic [7:0] octets[$];
    logic [7:0] ctrl;
    logic [7:0] base;
    logic carries_pid;
    logic carries_info;
    int shape;
    int n_digis;
    int n_fields;
    int blank_field;
    int n_tail;
    int cut;
    int f;
    int k;
    shape = $urandom_range(0, 99);
    if (shape < 8) begin
      n_tail = $urandom_range(1, 24);
      repeat (n_tail) octets.push_back(8'($urandom));
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: n_digis = 0;
        5, 6, 7:       n_digis = $urandom_range(1, 3);
        default:       n_digis = MaxDigis;
      endcase
      n_fields = n_digis + 2;
      blank_field = (shape < 13) ? $urandom_range(0, n_fields - 1) : -1;
      for (f = 0; f < n_fields; f++) begin
        for (k = 0; k < 6; k++) begin
          if (f == blank_field || $urandom_range(0, 3) == 0) octets.push_back(8'h40);
          else octets.push_back(8'($urandom));
        end
        base = 8'($urandom);
        // At the digipeater limit the end-of-address bit may be left clear.
        if (f == 0) base[0] = (shape >= 13 && shape < 18);
        else base[0] = (f == n_fields - 1) && (n_digis != MaxDigis || $urandom_range(0, 1) == 1);
        octets.push_back(base);
      end

      base = 8'($urandom);
      case ($urandom_range(0, 11))
        0:       ctrl = {base[7:1], 1'b0};
        1:       ctrl = {base[7:2], 2'b01};
        2, 9:    ctrl = CtrlUi | (base & CtrlPfMask);
        3:       ctrl = CtrlDm | (base & CtrlPfMask);
        4:       ctrl = CtrlSabm | (base & CtrlPfMask);
        5:       ctrl = CtrlSabme | (base & CtrlPfMask);
        6:       ctrl = CtrlDisc | (base & CtrlPfMask);
        7:       ctrl = CtrlUa | (base & CtrlPfMask);
        8:       ctrl = CtrlFrmr | (base & CtrlPfMask);
        10:      ctrl = {base[7:2], 2'b11};
        default: ctrl = base;
      endcase
      octets.push_back(ctrl);
      carries_pid = !ctrl[0] || ((ctrl & ~CtrlPfMask) == CtrlUi);
      carries_info = carries_pid || ((ctrl & ~CtrlPfMask) == CtrlFrmr);
      if (carries_pid) octets.push_back(8'($urandom));
      if (carries_info) begin
        n_tail = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
      end else begin
        n_tail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      end
      repeat (n_tail) octets.push_back(8'($urandom));

      if (shape >= 18 && shape < 28) begin
        cut = $urandom_range(1, octets.size());
        while (octets.size() > cut) void'(octets.pop_back());
      end
    end
    for (k = 0; k < octets.size(); k++) send_octet(octets[k], k == octets.size() - 1);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // Output checking and the count of cycles without any transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen_record.kind = m_axis_tuser;
        seen_record.role = m_axis_tdata[1:0];
        seen_record.call = m_axis_tdata[49:2];
        seen_record.ssid = m_axis_tdata[53:50];
        seen_record.ch = m_axis_tdata[54];
        seen_record.ftype = m_axis_tdata[58:55];
        seen_record.cmd = m_axis_tdata[59];
        seen_record.pf = m_axis_tdata[60];
        seen_record.ns = m_axis_tdata[63:61];
        seen_record.nr = m_axis_tdata[66:64];
        seen_record.octet = m_axis_tdata[74:67];
        seen_record.status = m_axis_tdata[76:75];
        if (expected_records.size() == 0) begin
          report_mismatch("record with none expected, kind", m_axis_tuser, 0);
        end else begin
          check_record(seen_record, expected_records.pop_front());
        end
        records_by_kind[m_axis_tuser]++;
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Watchdog.
  initial begin
    while (stall_cycles < StallLimit) @(posedge clk_i);
    $display("watchdog: no transaction for %0d cycles", StallLimit);
    $display("status: fail");
    $finish;
  end

  // Main sequence.
  initial begin
    stim_row_t row;
    int i;
    rst_ni = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    s_axis_tvalid = 1'b0;
    src_idle_pct = 21;
    sink_idle_pct = 71;
    clear_parser();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows; a typed status replaces the predicted one.
    for (i = 0; i < DirectedLen; i++) begin
      row = DirectedRows[i];
      send_octet(row.data, row.last);
      if (row.typed) begin
        void'(expected_records.pop_back());
        expected_records.push_back(status_record(row.stat));
      end
    end

    while (octets_sent < DirectedLen + 300) send_random_frame();

    src_idle_pct = 71;
    sink_idle_pct = 21;
    while (octets_sent < DirectedLen + 600) send_random_frame();

    // Long receiver hold-off while frames keep coming, then a full drain.
    hold_req = ~hold_req;
    repeat (4) send_random_frame();
    wait_for_records_drained();

    src_idle_pct = 0;
    sink_idle_pct = 0;
    while (octets_sent < DirectedLen + 900) send_random_frame();

    wait_for_records_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_records.size() != 0) begin
      report_mismatch("records never delivered, count", expected_records.size(), 0);
    end

    $display("run covered %0d octets in %0d frames, %0d of 12 frame types decoded",
             octets_sent, frames_sent, $countones(types_seen));
    $display("records checked: %0d address, %0d header, %0d payload, %0d status; %0d mismatches",
             records_by_kind[KindAddress], records_by_kind[KindHeader],
             records_by_kind[KindPayload], records_by_kind[KindStatus], mismatch_count);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/ax25fp_pkg.sv
rtl/ax25fp_parser.sv
rtl/ax25_frame_parser_top.sv
verif/ax25_frame_parser_top_tb.sv
